// ----- hw/rtl/cftv_pkg.sv -----
// Package for the CSV field type validator: type codes, parser phases and character classes.
package cftv_pkg;

  localparam int CharW = 8;
  localparam int TypeW = 5;
  localparam int MagW  = 33;
  localparam logic [MagW-1:0] MagCap = 33'h1_0000_0000;
  localparam logic DefaultAllowBlank = 1'b1;

  typedef enum logic [TypeW-1:0] {
    FT_TEXT = 5'd0, FT_CHAR = 5'd1,
    FT_I8 = 5'd2, FT_I16 = 5'd3, FT_I32 = 5'd4, FT_I64 = 5'd5,
    FT_U8 = 5'd6, FT_U16 = 5'd7, FT_U32 = 5'd8, FT_U64 = 5'd9,
    FT_F32 = 5'd10, FT_F64 = 5'd11, FT_BOOL = 5'd12
  } ftype_t;

  typedef enum logic [2:0] {
    IP_WS = 3'd0, IP_SIGN = 3'd1, IP_ZERO = 3'd2, IP_HEXPFX = 3'd3, IP_DIGITS = 3'd4
  } iphase_t;

  typedef enum logic [4:0] {
    FP_WS = 5'd0, FP_SIGN = 5'd1, FP_ZERO = 5'd2, FP_INT = 5'd3, FP_DOT0 = 5'd4,
    FP_FRAC = 5'd5, FP_E = 5'd6, FP_ES = 5'd7, FP_ED = 5'd8, FP_HX = 5'd9,
    FP_HI = 5'd10, FP_HD0 = 5'd11, FP_HF = 5'd12, FP_P = 5'd13, FP_PS = 5'd14,
    FP_PD = 5'd15, FP_I1 = 5'd16, FP_I2 = 5'd17, FP_INF = 5'd18, FP_IN4 = 5'd19,
    FP_IN5 = 5'd20, FP_IN6 = 5'd21, FP_IN7 = 5'd22, FP_INFTY = 5'd23, FP_N1 = 5'd24,
    FP_NA = 5'd25, FP_NAN = 5'd26, FP_NP = 5'd27, FP_NEND = 5'd28, FP_FAIL = 5'd29
  } fphase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0, RX_OCT = 2'd1, RX_HEX = 2'd2
  } radix_t;

  // Parser state for one field.
  typedef struct packed {
    fphase_t         fphase;
    iphase_t         iphase;
    logic [MagW-1:0] mag;
    logic            neg;
    radix_t          radix;
    logic [2:0]      ccount;
    logic            bm_true;
    logic            bm_false;
    logic            bm_pass;
    logic            bm_lead;
    logic            syn_fail;
    logic [2:0]      flen;
    logic            first_alpha;
    logic            nul_seen;
  } pstate_t;

  // One registered input beat.
  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic [TypeW-1:0] field_type;
    logic             last_in_field;
    logic             last_in_row;
  } beat_t;

  function automatic logic [7:0] low_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return low_case(c) >= 8'h61 && low_case(c) <= 8'h7A;
  endfunction

  // Digit value, 16 for a non-digit.
  function automatic logic [4:0] digit_val(input logic [7:0] c);
    logic [7:0] l;
    l = low_case(c);
    if (is_dec(c)) return 5'(c - 8'h30);
    if (l >= 8'h61 && l <= 8'h66) return 5'(l - 8'h57);
    return 5'd16;
  endfunction

  function automatic logic [7:0] true_char(input logic [2:0] i);
    case (i)
      3'd0: return 8'h74;
      3'd1: return 8'h72;
      3'd2: return 8'h75;
      default: return 8'h65;
    endcase
  endfunction

  function automatic logic [7:0] false_char(input logic [2:0] i);
    case (i)
      3'd0: return 8'h66;
      3'd1: return 8'h61;
      3'd2: return 8'h6C;
      3'd3: return 8'h73;
      default: return 8'h65;
    endcase
  endfunction

endpackage

// ----- hw/rtl/csv_field_type_validator.sv -----
// Top level of the CSV field type validator: input register, parser state and result register.
//
//  channel | signals                                             | dir
//  in      | valid, ready, char_code, field_type, last_in_*       | in
//  out     | out_valid, out_ready, field_valid, row_valid, row_done | out
//  cfg     | cfg_we, cfg_data (blank text enable)                 | in
//
// One beat a cycle while the output does not stall: a character is registered when
// accepted and parsed in the next cycle, when a field-ending beat also loads the result
// register if the output is free. Reset clears state and turns blank text back on.
// A stalled output holds only a field-ending beat; ready then stays low until it moves.
module csv_field_type_validator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid,
  output logic                          ready,
  input  logic [cftv_pkg::CharW-1:0]    char_code,
  input  logic [cftv_pkg::TypeW-1:0]    field_type,
  input  logic                          last_in_field,
  input  logic                          last_in_row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          field_valid,
  output logic                          row_valid,
  output logic                          row_done,
  input  logic                          cfg_we,
  input  logic                          cfg_data
);
  import cftv_pkg::*;

  logic    allow_blank;
  logic    in_full;
  beat_t   in_beat;
  pstate_t st;
  pstate_t st_next;
  pstate_t st_clear;
  logic    row_ok;
  logic    ok;
  logic    ends;
  logic    adv;
  logic    out_free;

  assign st_clear = '{fphase: FP_WS, iphase: IP_WS, mag: '0, neg: 1'b0, radix: RX_DEC,
                      ccount: 3'd0, bm_true: 1'b1, bm_false: 1'b1, bm_pass: 1'b0,
                      bm_lead: 1'b1, syn_fail: 1'b0, flen: 3'd0, first_alpha: 1'b0,
                      nul_seen: 1'b0};

  cftv_parse u_parse (.cur(st), .char_code(in_beat.char_code), .nxt(st_next));

  cftv_verdict u_verdict (
    .st(st_next), .field_type(in_beat.field_type),
    .blank_ok(allow_blank), .ok(ok)
  );

  assign ends     = in_beat.last_in_field || in_beat.last_in_row;
  assign out_free = !out_valid || out_ready;
  // The registered beat moves on unless it makes a result that cannot be stored.
  assign adv      = in_full && (!ends || out_free);
  assign ready    = !in_full || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_blank <= DefaultAllowBlank;
      in_full     <= 1'b0;
      out_valid   <= 1'b0;
      row_ok      <= 1'b1;
      st          <= st_clear;
    end else begin
      if (cfg_we) allow_blank <= cfg_data;
      if (ready) in_full <= valid;
      out_valid <= (out_valid && !out_ready) || (adv && ends);
      if (adv) begin
        if (ends) begin
          st          <= st_clear;
          field_valid <= ok;
          row_valid   <= row_ok && ok;
          row_done    <= in_beat.last_in_row;
          row_ok      <= in_beat.last_in_row ? 1'b1 : (row_ok && ok);
        end else begin
          st <= st_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid) in_beat <= '{char_code, field_type, last_in_field, last_in_row};
  end

endmodule

// ----- hw/rtl/cftv_parse.sv -----
// Per-character parser update: integer, float, bool and length trackers.
module cftv_parse (
  input  cftv_pkg::pstate_t    cur,
  input  logic [7:0]           char_code,
  output cftv_pkg::pstate_t    nxt
);
  import cftv_pkg::*;

  logic [7:0]  c;
  logic [7:0]  l;
  logic [4:0]  d;
  logic [4:0]  base;
  logic        dec;
  logic        hex;
  logic        sgn;
  logic        fail_i;
  logic [MagW+4:0] prod;
  logic [2:0]  cc;
  fphase_t     fn;

  assign c    = char_code;
  assign l    = low_case(c);
  assign d    = digit_val(c);
  assign dec  = is_dec(c);
  assign hex  = d < 5'd16;
  assign sgn  = c == 8'h2B || c == 8'h2D;
  assign base = cur.radix == RX_HEX ? 5'd16 : (cur.radix == RX_OCT ? 5'd8 : 5'd10);
  // Multiply by a radix of 8, 10 or 16 as shifts and adds.
  assign prod = (cur.radix == RX_HEX) ? {1'b0, cur.mag, 4'd0} + (MagW+5)'(d) :
                (cur.radix == RX_OCT) ? {2'd0, cur.mag, 3'd0} + (MagW+5)'(d) :
                {2'd0, cur.mag, 3'd0} + {4'd0, cur.mag, 1'b0} + (MagW+5)'(d);

  always_comb begin
    nxt = cur;
    fail_i = 1'b0;
    fn = FP_FAIL;
    cc = cur.ccount;
    if (c == 8'd0) nxt.nul_seen = 1'b1;
    if (!(c == 8'd0 || cur.nul_seen)) begin
      if (cur.flen == 3'd0) nxt.first_alpha = is_alpha(c);
      if (cur.flen != 3'd7) nxt.flen = cur.flen + 3'd1;

      // Integer parser.
      if (!cur.syn_fail) begin
        case (cur.iphase)
          IP_WS, IP_SIGN: begin
            if (cur.iphase == IP_WS && is_space(c)) begin
            end else if (cur.iphase == IP_WS && sgn) begin
              nxt.neg = c == 8'h2D;
              nxt.iphase = IP_SIGN;
            end else if (c == 8'h30) begin
              nxt.iphase = IP_ZERO;
            end else if (dec) begin
              nxt.radix = RX_DEC;
              nxt.mag = MagW'(d);
              nxt.iphase = IP_DIGITS;
            end else begin
              fail_i = 1'b1;
            end
          end
          IP_ZERO: begin
            if (l == 8'h78) nxt.iphase = IP_HEXPFX;
            else if (c >= 8'h30 && c <= 8'h37) begin
              nxt.radix = RX_OCT;
              nxt.mag = MagW'(d);
              nxt.iphase = IP_DIGITS;
            end else fail_i = 1'b1;
          end
          IP_HEXPFX: begin
            if (hex) begin
              nxt.radix = RX_HEX;
              nxt.mag = MagW'(d);
              nxt.iphase = IP_DIGITS;
            end else fail_i = 1'b1;
          end
          default: begin
            if (d < base) nxt.mag = (prod > (MagW+5)'(MagCap)) ? MagCap : MagW'(prod);
            else fail_i = 1'b1;
          end
        endcase
        if (fail_i) nxt.syn_fail = 1'b1;
      end

      // Float recogniser.
      case (cur.fphase)
        FP_WS, FP_SIGN: begin
          if (cur.fphase == FP_WS && is_space(c)) fn = FP_WS;
          else if (cur.fphase == FP_WS && sgn) fn = FP_SIGN;
          else if (c == 8'h30) fn = FP_ZERO;
          else if (dec) fn = FP_INT;
          else if (c == 8'h2E) fn = FP_DOT0;
          else if (l == 8'h69) fn = FP_I1;
          else if (l == 8'h6E) fn = FP_N1;
        end
        FP_ZERO, FP_INT: begin
          if (dec) fn = FP_INT;
          else if (c == 8'h2E) fn = FP_FRAC;
          else if (l == 8'h65) fn = FP_E;
          else if (cur.fphase == FP_ZERO && l == 8'h78) fn = FP_HX;
        end
        FP_DOT0: if (dec) fn = FP_FRAC;
        FP_FRAC: begin
          if (dec) fn = FP_FRAC;
          else if (l == 8'h65) fn = FP_E;
        end
        FP_E: begin
          if (sgn) fn = FP_ES;
          else if (dec) fn = FP_ED;
        end
        FP_ES, FP_ED: if (dec) fn = FP_ED;
        FP_HX: begin
          if (hex) fn = FP_HI;
          else if (c == 8'h2E) fn = FP_HD0;
        end
        FP_HI: begin
          if (hex) fn = FP_HI;
          else if (c == 8'h2E) fn = FP_HF;
          else if (l == 8'h70) fn = FP_P;
        end
        FP_HD0: if (hex) fn = FP_HF;
        FP_HF: begin
          if (hex) fn = FP_HF;
          else if (l == 8'h70) fn = FP_P;
        end
        FP_P: begin
          if (sgn) fn = FP_PS;
          else if (dec) fn = FP_PD;
        end
        FP_PS, FP_PD: if (dec) fn = FP_PD;
        FP_I1:  if (l == 8'h6E) fn = FP_I2;
        FP_I2:  if (l == 8'h66) fn = FP_INF;
        FP_INF: if (l == 8'h69) fn = FP_IN4;
        FP_IN4: if (l == 8'h6E) fn = FP_IN5;
        FP_IN5: if (l == 8'h69) fn = FP_IN6;
        FP_IN6: if (l == 8'h74) fn = FP_IN7;
        FP_IN7: if (l == 8'h79) fn = FP_INFTY;
        FP_N1:  if (l == 8'h61) fn = FP_NA;
        FP_NA:  if (l == 8'h6E) fn = FP_NAN;
        FP_NAN: if (c == 8'h28) fn = FP_NP;
        FP_NP: begin
          if (dec || is_alpha(c) || c == 8'h5F) fn = FP_NP;
          else if (c == 8'h29) fn = FP_NEND;
        end
        default: fn = FP_FAIL;
      endcase
      nxt.fphase = fn;

      // Bool prefix matcher.
      if (!(cur.bm_lead && (c == 8'h20 || c == 8'h09))) begin
        if (cur.bm_lead) begin
          nxt.bm_lead = 1'b0;
          if (c == 8'h31 || c == 8'h30) nxt.bm_pass = 1'b1;
        end
        if (cc >= 3'd4 || l != true_char(cc)) nxt.bm_true = 1'b0;
        if (cc >= 3'd5 || l != false_char(cc)) nxt.bm_false = 1'b0;
        if (cc != 3'd7) nxt.ccount = cc + 3'd1;
        if (nxt.bm_true && nxt.ccount == 3'd4) nxt.bm_pass = 1'b1;
        if (nxt.bm_false && nxt.ccount == 3'd5) nxt.bm_pass = 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/cftv_verdict.sv -----
// Field verdict: selects the check for the field's type code.
module cftv_verdict (
  input  cftv_pkg::pstate_t          st,
  input  logic [cftv_pkg::TypeW-1:0] field_type,
  input  logic                       blank_ok,
  output logic                       ok
);
  import cftv_pkg::*;

  logic int_ok;
  logic [MagW-1:0] mag;

  assign mag = st.mag;
  assign int_ok = !st.syn_fail && (st.iphase == IP_ZERO || st.iphase == IP_DIGITS);

  always_comb begin
    case (field_type)
      FT_TEXT:  ok = st.flen != 3'd0 || blank_ok;
      FT_CHAR:  ok = st.flen == 3'd1 && st.first_alpha;
      FT_I8:    ok = int_ok && (st.neg ? mag <= MagW'(128) : mag <= MagW'(127));
      FT_I16:   ok = int_ok && (st.neg ? mag <= MagW'(32768) : mag <= MagW'(32767));
      FT_I32:   ok = int_ok && (st.neg ? mag <= MagW'(33'h8000_0000) :
                                         mag <= MagW'(33'h7FFF_FFFF));
      FT_I64, FT_U64: ok = int_ok;
      FT_U8:    ok = int_ok && (st.neg ? mag == '0 : mag <= MagW'(255));
      FT_U16:   ok = int_ok && (st.neg ? mag == '0 : mag <= MagW'(65535));
      FT_U32:   ok = int_ok && (st.neg ? mag == '0 : mag <= MagW'(33'hFFFF_FFFF));
      FT_F32, FT_F64:
        ok = st.fphase == FP_ZERO || st.fphase == FP_INT || st.fphase == FP_FRAC ||
             st.fphase == FP_ED || st.fphase == FP_HI || st.fphase == FP_HF ||
             st.fphase == FP_PD || st.fphase == FP_INF || st.fphase == FP_INFTY ||
             st.fphase == FP_NAN || st.fphase == FP_NEND;
      FT_BOOL:  ok = st.bm_pass && (st.flen == 3'd4 || st.flen == 3'd5);
      default:  ok = 1'b0;
    endcase
  end

endmodule

// ----- tb/csv_field_type_validator_tb.sv -----
// Testbench for the CSV field type validator: directed and random fields checked against a predictor.
module csv_field_type_validator_tb;
  import cftv_pkg::*;

  typedef logic [7:0] chars_t[$];

  // Predicts the verdict for every field and compares it with what comes out.
  class field_checker;
    logic allow_blank;
    fphase_t fph;
    iphase_t iph;
    longint unsigned mag;
    bit neg;
    radix_t rdx;
    int cc;
    bit bt, bf, bp, bl;
    bit syn;
    int flen;
    bit fa, nul;
    bit row_ok;
    logic [2:0] verdicts[$];
    int errors;

    function new();
      allow_blank = DefaultAllowBlank;
      row_ok = 1;
      errors = 0;
      clear();
    endfunction

    function void clear();
      fph = FP_WS;
      iph = IP_WS;
      mag = 0;
      neg = 0;
      rdx = RX_DEC;
      cc = 0;
      bt = 1; bf = 1; bp = 0; bl = 1;
      syn = 0;
      flen = 0;
      fa = 0;
      nul = 0;
    endfunction

    function logic [7:0] lower(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function bit blank(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function bit decimal(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit letter(logic [7:0] c);
      return lower(c) >= "a" && lower(c) <= "z";
    endfunction

    function int digit_of(logic [7:0] c);
      if (decimal(c)) return c - "0";
      if (lower(c) >= "a" && lower(c) <= "f") return lower(c) - "a" + 10;
      return 16;
    endfunction

    function void int_char(logic [7:0] c);
      int d;
      int base;
      d = digit_of(c);
      base = rdx == RX_HEX ? 16 : (rdx == RX_OCT ? 8 : 10);
      if (syn) return;
      if (iph == IP_WS && blank(c)) return;
      if (iph == IP_WS && (c == "+" || c == "-")) begin
        neg = c == "-";
        iph = IP_SIGN;
        return;
      end
      if (iph == IP_WS || iph == IP_SIGN) begin
        if (c == "0") iph = IP_ZERO;
        else if (c >= "1" && c <= "9") begin
          rdx = RX_DEC; mag = d; iph = IP_DIGITS;
        end else syn = 1;
      end else if (iph == IP_ZERO) begin
        if (lower(c) == "x") iph = IP_HEXPFX;
        else if (c >= "0" && c <= "7") begin
          rdx = RX_OCT; mag = d; iph = IP_DIGITS;
        end else syn = 1;
      end else if (iph == IP_HEXPFX) begin
        if (d < 16) begin
          rdx = RX_HEX; mag = d; iph = IP_DIGITS;
        end else syn = 1;
      end else begin
        if (d < base) begin
          mag = mag * base + d;
          if (mag > MagCap) mag = MagCap;
        end else syn = 1;
      end
    endfunction

    function fphase_t word(logic [7:0] l, logic [7:0] want, fphase_t nxt);
      return l == want ? nxt : FP_FAIL;
    endfunction

    function void float_char(logic [7:0] c);
      logic [7:0] l;
      bit dg, hx, sg;
      fphase_t n;
      l = lower(c);
      dg = decimal(c);
      hx = digit_of(c) < 16;
      sg = c == "+" || c == "-";
      n = FP_FAIL;
      case (fph)
        FP_WS, FP_SIGN: begin
          if (fph == FP_WS && blank(c)) n = FP_WS;
          else if (fph == FP_WS && sg) n = FP_SIGN;
          else if (c == "0") n = FP_ZERO;
          else if (dg) n = FP_INT;
          else if (c == ".") n = FP_DOT0;
          else if (l == "i") n = FP_I1;
          else if (l == "n") n = FP_N1;
        end
        FP_ZERO, FP_INT: begin
          if (dg) n = FP_INT;
          else if (c == ".") n = FP_FRAC;
          else if (l == "e") n = FP_E;
          else if (fph == FP_ZERO && l == "x") n = FP_HX;
        end
        FP_DOT0: if (dg) n = FP_FRAC;
        FP_FRAC: if (dg) n = FP_FRAC; else if (l == "e") n = FP_E;
        FP_E: if (sg) n = FP_ES; else if (dg) n = FP_ED;
        FP_ES, FP_ED: if (dg) n = FP_ED;
        FP_HX: if (hx) n = FP_HI; else if (c == ".") n = FP_HD0;
        FP_HI: if (hx) n = FP_HI; else if (c == ".") n = FP_HF; else if (l == "p") n = FP_P;
        FP_HD0: if (hx) n = FP_HF;
        FP_HF: if (hx) n = FP_HF; else if (l == "p") n = FP_P;
        FP_P: if (sg) n = FP_PS; else if (dg) n = FP_PD;
        FP_PS, FP_PD: if (dg) n = FP_PD;
        FP_I1: n = word(l, "n", FP_I2);
        FP_I2: n = word(l, "f", FP_INF);
        FP_INF: n = word(l, "i", FP_IN4);
        FP_IN4: n = word(l, "n", FP_IN5);
        FP_IN5: n = word(l, "i", FP_IN6);
        FP_IN6: n = word(l, "t", FP_IN7);
        FP_IN7: n = word(l, "y", FP_INFTY);
        FP_N1: n = word(l, "a", FP_NA);
        FP_NA: n = word(l, "n", FP_NAN);
        FP_NAN: n = word(c, "(", FP_NP);
        FP_NP: if (dg || letter(c) || c == "_") n = FP_NP; else if (c == ")") n = FP_NEND;
        default: n = FP_FAIL;
      endcase
      fph = n;
    endfunction

    function void bool_char(logic [7:0] c);
      string tw, fw;
      logic [7:0] l;
      tw = "true";
      fw = "false";
      l = lower(c);
      if (bl && (c == " " || c == 8'd9)) return;
      if (bl) begin
        bl = 0;
        if (c == "1" || c == "0") bp = 1;
      end
      if (cc >= 4 || l != tw[cc]) bt = 0;
      if (cc >= 5 || l != fw[cc]) bf = 0;
      if (cc < 7) cc++;
      if (bt && cc == 4) bp = 1;
      if (bf && cc == 5) bp = 1;
    endfunction

    function bit int_fits(longint unsigned maxv, bit uns);
      if (syn || (iph != IP_ZERO && iph != IP_DIGITS)) return 0;
      if (neg) return uns ? mag == 0 : mag <= maxv + 1;
      return mag <= maxv;
    endfunction

    function bit field_ok(logic [4:0] t);
      case (t)
        FT_TEXT: return flen != 0 || allow_blank;
        FT_CHAR: return flen == 1 && fa;
        FT_I8: return int_fits(64'h7F, 0);
        FT_I16: return int_fits(64'h7FFF, 0);
        FT_I32: return int_fits(64'h7FFF_FFFF, 0);
        FT_I64, FT_U64: return int_fits(MagCap, 0);
        FT_U8: return int_fits(64'hFF, 1);
        FT_U16: return int_fits(64'hFFFF, 1);
        FT_U32: return int_fits(64'hFFFF_FFFF, 1);
        FT_F32, FT_F64:
          return fph inside {FP_ZERO, FP_INT, FP_FRAC, FP_ED, FP_HI, FP_HF, FP_PD,
                             FP_INF, FP_INFTY, FP_NAN, FP_NEND};
        FT_BOOL: return bp && (flen == 4 || flen == 5);
        default: return 0;
      endcase
    endfunction

    function void note_beat(logic [7:0] c, logic [4:0] t, logic lf, logic lr);
      bit ok;
      if (c == 0) nul = 1;
      if (!nul) begin
        if (flen == 0) fa = letter(c);
        if (flen < 7) flen++;
        int_char(c);
        float_char(c);
        bool_char(c);
      end
      if (!lf && !lr) return;
      ok = field_ok(t);
      row_ok = row_ok && ok;
      verdicts.push_back({ok, row_ok, lr});
      if (lr) row_ok = 1;
      clear();
    endfunction

    function void check_result(logic fv, logic rv, logic rd);
      logic [2:0] want;
      if (verdicts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result fv=%b rv=%b rd=%b", fv, rv, rd);
        return;
      end
      want = verdicts.pop_front();
      if (want !== {fv, rv, rd}) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected fv=%b rv=%b rd=%b, got fv=%b rv=%b rd=%b",
                   want[2], want[1], want[0], fv, rv, rd);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic valid = 0;
  logic ready;
  logic [7:0] char_code = 0;
  logic [4:0] field_type = 0;
  logic last_in_field = 0;
  logic last_in_row = 0;
  logic out_valid;
  logic out_ready = 0;
  logic field_valid, row_valid, row_done;
  logic cfg_we = 0;
  logic cfg_data = 0;

  field_checker board = new();
  int in_idle = 0;
  int out_idle = 0;
  int beats_sent = 0;

  csv_field_type_validator uut (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready),
    .char_code(char_code), .field_type(field_type),
    .last_in_field(last_in_field), .last_in_row(last_in_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .field_valid(field_valid), .row_valid(row_valid), .row_done(row_done),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (valid && ready) board.note_beat(char_code, field_type, last_in_field, last_in_row);
      if (out_valid && out_ready) board.check_result(field_valid, row_valid, row_done);
    end
  end

  always @(posedge clk) out_ready <= $urandom_range(99) >= out_idle;

  task automatic send_beat(logic [7:0] c, logic [4:0] t, logic lf, logic lr);
    if ($urandom_range(99) < in_idle) begin
      valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < in_idle) @(posedge clk);
    end
    valid <= 1;
    char_code <= c;
    field_type <= t;
    last_in_field <= lf;
    last_in_row <= lr;
    do @(posedge clk); while (!ready);
    beats_sent++;
  endtask

  // On noisy fields the type changes on earlier beats and a row may end
  // without the field mark.
  task automatic send_field(chars_t q, logic [4:0] t, bit end_row, bit noise);
    logic [4:0] ty;
    logic lf;
    if (q.size() == 0) q.push_back(8'd0);
    foreach (q[i]) begin
      ty = (noise && i != q.size() - 1) ? 5'($urandom_range(31)) : t;
      lf = i == q.size() - 1;
      if (lf && end_row && noise && $urandom_range(3) == 0) lf = 0;
      send_beat(q[i], ty, lf, lf ? end_row : (end_row && i == q.size() - 1));
    end
  endtask

  function automatic chars_t to_chars(string s);
    chars_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic string digits(int n, int base);
    string s, set;
    set = "0123456789abcdefABCDEF";
    s = "";
    for (int i = 0; i < n; i++)
      s = {s, string'(set[base == 16 ? $urandom_range(21) : $urandom_range(base - 1)])};
    return s;
  endfunction

  function automatic string lead(int maxn);
    string s, ws;
    ws = " \t\n";
    s = "";
    repeat ($urandom_range(maxn)) s = {s, string'(ws[$urandom_range(2)])};
    return s;
  endfunction

  function automatic string int_text();
    string s;
    string nz;
    longint unsigned edges[12] = '{127, 128, 255, 256, 32767, 32768, 65535, 65536,
                                   2147483647, 2147483648, 4294967295, 4294967296};
    nz = "123456789";
    s = lead($urandom_range(3) == 0 ? 2 : 0);
    case ($urandom_range(3))
      0: s = {s, "+"};
      1: s = {s, "-"};
      default: ;
    endcase
    case ($urandom_range(5))
      0: s = {s, string'(nz[$urandom_range(8)]), digits($urandom_range(10), 10)};
      1: s = {s, "0", digits($urandom_range(11), 8)};
      2: s = {s, string'($urandom_range(1) ? "0x" : "0X"), digits($urandom_range(1, 9), 16)};
      3: s = {s, $sformatf("%0d", edges[$urandom_range(11)])};
      4: s = {s, $sformatf("0x%0h", edges[$urandom_range(11)])};
      default: s = {s, "0"};
    endcase
    return s;
  endfunction

  function automatic string float_text();
    string s;
    s = {lead(1), string'($urandom_range(2) == 0 ? "-" : ($urandom_range(3) == 0 ? "+" : ""))};
    case ($urandom_range(6))
      0: s = {s, digits($urandom_range(3), 10), ".", digits($urandom_range(3), 10)};
      1: s = {s, digits($urandom_range(1, 3), 10), "e", string'($urandom_range(1) ? "-" : ""),
              digits($urandom_range(2), 10)};
      2: s = {s, "0x", digits($urandom_range(2), 16), ".", digits($urandom_range(2), 16),
              $urandom_range(1) ? {"p", digits($urandom_range(2), 10)} : ""};
      3: s = {s, string'($urandom_range(1) ? "inf" : "infinity")};
      4: s = {s, "nan", $urandom_range(1) ? {"(", digits($urandom_range(2), 16), "_)"} : ""};
      5: s = {s, "0", digits($urandom_range(2), 10), ".e+", digits(1, 10)};
      default: s = {s, digits($urandom_range(1, 4), 10)};
    endcase
    if ($urandom_range(3) == 0) s = s.toupper();
    return s;
  endfunction

  function automatic string bool_text();
    string words[6] = '{"true", "false", "1", "0", "tru", "fals"};
    string s;
    s = {string'($urandom_range(3) == 0 ? " \t" : ""), words[$urandom_range(5)]};
    if ($urandom_range(2) == 0) s = {s, digits($urandom_range(2), 16)};
    if ($urandom_range(2) == 0) s = s.toupper();
    return s;
  endfunction

  function automatic chars_t random_field(logic [4:0] t);
    chars_t q;
    int k;
    case (t)
      FT_I8, FT_I16, FT_I32, FT_I64, FT_U8, FT_U16, FT_U32, FT_U64: q = to_chars(int_text());
      FT_F32, FT_F64: q = to_chars(float_text());
      FT_BOOL: q = to_chars(bool_text());
      FT_CHAR: begin
        q.push_back($urandom_range(1) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(1, 255)));
        if ($urandom_range(4) == 0) q.push_back(8'($urandom_range(1, 255)));
      end
      default: repeat ($urandom_range(8)) q.push_back(8'($urandom_range(1, 255)));
    endcase
    if (q.size() > 0 && $urandom_range(9) == 0) begin
      k = $urandom_range(q.size() - 1);
      q[k] = 8'($urandom_range(1, 255));
    end
    // A zero cuts the text short; what follows it must be ignored.
    if ($urandom_range(11) == 0) begin
      q.push_back(8'd0);
      repeat ($urandom_range(3)) q.push_back(8'($urandom_range(255)));
    end
    return q;
  endfunction

  task automatic random_rows(int quota);
    logic [4:0] t;
    int n;
    int stop_at;
    stop_at = beats_sent + quota;
    while (beats_sent < stop_at) begin
      n = $urandom_range(1, 5);
      for (int f = 0; f < n; f++) begin
        t = $urandom_range(7) == 0 ? 5'($urandom_range(31)) : 5'($urandom_range(12));
        send_field(random_field(t), t, f == n - 1, $urandom_range(9) == 0);
      end
    end
  endtask

  task automatic write_allow_blank(logic v);
    valid <= 0;
    @(posedge clk);
    while (board.verdicts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    board.allow_blank = v;
  endtask

  task automatic directed_fields();
    chars_t q;
    send_field(to_chars(""), FT_TEXT, 0, 0);
    send_field(to_chars("a"), FT_CHAR, 0, 0);
    send_field(to_chars("Z9"), FT_CHAR, 1, 0);
    send_field(to_chars("-128"), FT_I8, 0, 0);
    send_field(to_chars("128"), FT_I8, 0, 0);
    send_field(to_chars("-0"), FT_U8, 0, 0);
    send_field(to_chars("0xFFFF"), FT_U16, 1, 0);
    send_field(to_chars("4294967295"), FT_U32, 0, 0);
    send_field(to_chars("4294967296"), FT_U32, 0, 0);
    send_field(to_chars(" \t-2147483648"), FT_I32, 0, 0);
    send_field(to_chars("0777"), FT_I16, 0, 0);
    send_field(to_chars("08"), FT_I64, 0, 0);
    send_field(to_chars("99999999999999"), FT_U64, 1, 0);
    send_field(to_chars("1.5e-3"), FT_F32, 0, 0);
    send_field(to_chars("0x1.8P+2"), FT_F64, 0, 0);
    send_field(to_chars("Infinity"), FT_F32, 0, 0);
    send_field(to_chars("nan(x_1)"), FT_F64, 1, 0);
    send_field(to_chars(" TRUE"), FT_BOOL, 0, 0);
    send_field(to_chars("1abc"), FT_BOOL, 0, 0);
    send_field(to_chars("falsey"), FT_BOOL, 1, 0);
    send_field(to_chars("2024"), 5'd13, 0, 0);
    send_field(to_chars("x"), 5'd31, 1, 0);
    q = to_chars("12");
    q.push_back(8'd0);
    q.push_back("z");
    send_field(q, FT_U8, 0, 0);
    // A row end without the field mark still closes the field.
    send_beat("7", FT_I8, 0, 1);
  endtask

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    directed_fields();
    write_allow_blank(0);
    send_field(to_chars(""), FT_TEXT, 1, 0);
    in_idle = 14; out_idle = 67;
    random_rows(400);
    write_allow_blank(1);
    in_idle = 67; out_idle = 14;
    random_rows(400);
    write_allow_blank(0);
    in_idle = 0; out_idle = 0;
    random_rows(400);
    valid <= 0;
    @(posedge clk);
    while (board.verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
